// ----- design/mll_pkg.sv -----
// ----------------------------------------------------------------------------
// mll_pkg
// Shared types, token kinds and keyword lookup for the mini-language lexer.
// ----------------------------------------------------------------------------
package mll_pkg;

	localparam int MAX_WORD_LETTERS = 9;
	localparam int NUMBER_BITS      = 31;
	localparam int KW_LETTERS       = 5;
	localparam int LEN_W            = $clog2(MAX_WORD_LETTERS + 2);
	localparam int LET_IDX_W        = $clog2(KW_LETTERS);

	localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_WORD,
		MODE_HELD
	} mode_t;

	localparam logic [4:0] KIND_END    = 5'd0;
	localparam logic [4:0] KIND_NUM    = 5'd1;
	localparam logic [4:0] KIND_NAME   = 5'd2;
	localparam logic [4:0] KIND_WHILE  = 5'd3;
	localparam logic [4:0] KIND_DO     = 5'd4;
	localparam logic [4:0] KIND_DONE   = 5'd5;
	localparam logic [4:0] KIND_IF     = 5'd6;
	localparam logic [4:0] KIND_THEN   = 5'd7;
	localparam logic [4:0] KIND_FI     = 5'd8;
	localparam logic [4:0] KIND_PRINT  = 5'd9;
	localparam logic [4:0] KIND_GT     = 5'd10;
	localparam logic [4:0] KIND_GE     = 5'd11;
	localparam logic [4:0] KIND_EQ     = 5'd12;
	localparam logic [4:0] KIND_NE     = 5'd13;
	localparam logic [4:0] KIND_LE     = 5'd14;
	localparam logic [4:0] KIND_LT     = 5'd15;
	localparam logic [4:0] KIND_ASSIGN = 5'd16;
	localparam logic [4:0] KIND_ADD    = 5'd17;
	localparam logic [4:0] KIND_SUB    = 5'd18;
	localparam logic [4:0] KIND_MUL    = 5'd19;
	localparam logic [4:0] KIND_DIV    = 5'd20;
	localparam logic [4:0] KIND_SEMI   = 5'd21;
	localparam logic [4:0] KIND_ERR    = 5'd22;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SYMBOL = 2'd1;
	localparam logic [1:0] ERR_WORD   = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_end;
	} lex_in_t;

	typedef struct packed {
		logic [4:0]             token_kind;
		logic [NUMBER_BITS-1:0] number_value;
		logic [7:0]             name_letter;
		logic [1:0]             error_code;
		logic                   last;
	} lex_tok_t;

	// first letter in the top byte
	function automatic logic [4:0] kw_kind(input logic [KW_LETTERS*8-1:0] word,
		input logic [LEN_W-1:0] len);
		logic [4:0] kind;
		kind = KIND_ERR;
		case (len)
			LEN_W'(2): begin
				if (word[39:24] == "do")
					kind = KIND_DO;
				else if (word[39:24] == "if")
					kind = KIND_IF;
				else if (word[39:24] == "fi")
					kind = KIND_FI;
			end
			LEN_W'(4): begin
				if (word[39:8] == "done")
					kind = KIND_DONE;
				else if (word[39:8] == "then")
					kind = KIND_THEN;
			end
			LEN_W'(5): begin
				if (word == "while")
					kind = KIND_WHILE;
				else if (word == "print")
					kind = KIND_PRINT;
			end
			default: kind = KIND_ERR;
		endcase
		return kind;
	endfunction

endpackage

// ----- design/mini_language_lexer.sv -----
// ----------------------------------------------------------------------------
// mini_language_lexer
// Streaming lexer: one source byte per beat in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one beat per source byte, or a beat with is_end set to close
//   the stream. tok channel: one beat per token, last marks the final token
//   caused by a source beat.
//   Each source beat is scanned in the cycle it is taken; its tokens (none,
//   one or two) are written into a four-entry output queue, and tok shows
//   the head of that queue. A source beat is taken every cycle as long
//   as the queue has two free entries, so the rate is one byte per cycle
//   except where tokens leave slower than they are made: a beat giving two
//   tokens needs two beats on tok.
//   When tok is stalled the queue fills and src_stall rises once fewer than
//   two entries are free; nothing is dropped.
//   Reset clears the scan state and empties the queue. After an error token
//   every further source beat is taken and ignored until the next reset.
// ----------------------------------------------------------------------------
module mini_language_lexer
	import mll_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  lex_in_t  src_data,
	output logic     tok_valid,
	input  logic     tok_stall,
	output lex_tok_t tok_data
);

	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	mode_t                  mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [NUMBER_BITS-1:0] accum_q, accum_d;
	logic [LEN_W-1:0]       len_q, len_d;
	logic                   halted_q, halted_d;
	logic [7:0]             letters_q [KW_LETTERS];
	logic                   let_we;
	logic [LET_IDX_W-1:0]   let_idx;

	lex_tok_t               q_q [Q_DEPTH];
	logic [QP_W-1:0]        wptr_q, rptr_q;
	logic [QC_W-1:0]        cnt_q;

	logic                   accept, pop;
	logic [7:0]             c;
	logic                   c_space, c_digit, c_letter;
	logic                   fl_valid, st_valid;
	lex_tok_t               fl_tok, st_tok, res0, res1;
	logic [1:0]             n_res;
	logic [NUMBER_BITS+3:0] acc_wide;
	logic [KW_LETTERS*8-1:0] word;

	assign accept    = src_valid && !src_stall;
	assign pop       = tok_valid && !tok_stall;
	assign src_stall = cnt_q > QC_W'(Q_DEPTH - 2);
	assign tok_valid = cnt_q != '0;
	assign tok_data  = q_q[rptr_q];

	assign c        = src_data.char_code;
	assign c_space  = c inside {[8'd9:8'd13], 8'd32};
	assign c_digit  = c inside {["0":"9"]};
	assign c_letter = c inside {["a":"z"], ["A":"Z"]};

	assign acc_wide = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
		+ (NUMBER_BITS+4)'(c[3:0]);

	always_comb begin
		for (int i = 0; i < KW_LETTERS; i++)
			word[(KW_LETTERS-1-i)*8 +: 8] = letters_q[i];
	end

	// pending token flushed by a delimiter or end
	always_comb begin
		fl_valid = 1'b0;
		fl_tok   = '0;
		case (mode_q)
			MODE_NUM: begin
				fl_valid            = 1'b1;
				fl_tok.token_kind   = KIND_NUM;
				fl_tok.number_value = accum_q;
			end
			MODE_WORD: begin
				fl_valid = 1'b1;
				if (len_q == LEN_W'(1)) begin
					fl_tok.token_kind  = KIND_NAME;
					fl_tok.name_letter = letters_q[0];
				end else if (len_q > LEN_W'(MAX_WORD_LETTERS)) begin
					fl_tok.token_kind = KIND_ERR;
					fl_tok.error_code = ERR_WORD;
				end else begin
					fl_tok.token_kind = kw_kind(word, len_q);
					if (fl_tok.token_kind == KIND_ERR)
						fl_tok.error_code = ERR_WORD;
				end
			end
			MODE_HELD: begin
				fl_valid = 1'b1;
				if (held_q == ">")
					fl_tok.token_kind = KIND_GT;
				else if (held_q == "<")
					fl_tok.token_kind = KIND_LT;
				else begin
					fl_tok.token_kind = KIND_ERR;
					fl_tok.error_code = ERR_SYMBOL;
				end
			end
			default: fl_valid = 1'b0;
		endcase
	end

	// next state and tokens for the accepted beat
	always_comb begin
		mode_d   = mode_q;
		held_d   = held_q;
		accum_d  = accum_q;
		len_d    = len_q;
		halted_d = halted_q;
		let_we   = 1'b0;
		let_idx  = '0;
		st_valid = 1'b0;
		st_tok   = '0;
		res0     = '0;
		res1     = '0;
		n_res    = 2'd0;
		if (accept && !halted_q) begin
			if (src_data.is_end) begin
				mode_d = MODE_IDLE;
				if (fl_valid && fl_tok.token_kind == KIND_ERR) begin
					res0     = fl_tok;
					n_res    = 2'd1;
					halted_d = 1'b1;
				end else if (fl_valid) begin
					res0  = fl_tok;
					n_res = 2'd2;
				end else begin
					n_res = 2'd1;
				end
			end else if (mode_q == MODE_NUM && c_digit) begin
				accum_d = (acc_wide > {4'b0, NUM_MAX}) ? NUM_MAX
					: acc_wide[NUMBER_BITS-1:0];
			end else if (mode_q == MODE_WORD && c_letter) begin
				if (len_q <= LEN_W'(MAX_WORD_LETTERS)) begin
					if (len_q < LEN_W'(KW_LETTERS)) begin
						let_we  = 1'b1;
						let_idx = len_q[LET_IDX_W-1:0];
					end
					len_d = len_q + LEN_W'(1);
				end
			end else if (mode_q == MODE_HELD && c == "=") begin
				mode_d = MODE_IDLE;
				n_res  = 2'd1;
				case (held_q)
					">":     res0.token_kind = KIND_GE;
					"<":     res0.token_kind = KIND_LE;
					"=":     res0.token_kind = KIND_EQ;
					"!":     res0.token_kind = KIND_NE;
					default: res0.token_kind = KIND_ASSIGN;
				endcase
			end else begin
				mode_d = MODE_IDLE;
				if (fl_valid && fl_tok.token_kind == KIND_ERR) begin
					res0     = fl_tok;
					n_res    = 2'd1;
					halted_d = 1'b1;
				end else begin
					if (c_space) begin
						st_valid = 1'b0;
					end else if (c_digit) begin
						mode_d  = MODE_NUM;
						accum_d = NUMBER_BITS'(c[3:0]);
					end else if (c_letter) begin
						mode_d = MODE_WORD;
						let_we = 1'b1;
						len_d  = LEN_W'(1);
					end else begin
						st_valid = 1'b1;
						case (c)
							">", "<", "=", "!", ":": begin
								st_valid = 1'b0;
								mode_d   = MODE_HELD;
								held_d   = c;
							end
							"+":     st_tok.token_kind = KIND_ADD;
							"-":     st_tok.token_kind = KIND_SUB;
							"*":     st_tok.token_kind = KIND_MUL;
							"/":     st_tok.token_kind = KIND_DIV;
							";":     st_tok.token_kind = KIND_SEMI;
							default: begin
								st_tok.token_kind = KIND_ERR;
								st_tok.error_code = ERR_SYMBOL;
								halted_d          = 1'b1;
							end
						endcase
					end
					if (fl_valid) begin
						res0  = fl_tok;
						res1  = st_tok;
						n_res = st_valid ? 2'd2 : 2'd1;
					end else if (st_valid) begin
						res0  = st_tok;
						n_res = 2'd1;
					end
				end
			end
			if (n_res == 2'd1)
				res0.last = 1'b1;
			if (n_res == 2'd2)
				res1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			held_q   <= '0;
			accum_q  <= '0;
			len_q    <= '0;
			halted_q <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			held_q   <= held_d;
			accum_q  <= accum_d;
			len_q    <= len_d;
			halted_q <= halted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (let_we)
			letters_q[let_idx] <= c;
	end

	// output queue
	always_ff @(posedge clk) begin
		if (n_res != 2'd0)
			q_q[wptr_q] <= res0;
		if (n_res == 2'd2)
			q_q[wptr_q + QP_W'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QP_W'(n_res);
			if (pop)
				rptr_q <= rptr_q + QP_W'(1);
			cnt_q <= cnt_q + QC_W'(n_res) - QC_W'(pop);
		end
	end

endmodule

// ----- bench/mini_language_lexer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_language_lexer_tb
// Drives source bytes and end markers into the lexer in random bursts while
// the token side stalls on its own pattern. A scanner model in the bench works
// out the tokens for every accepted byte, and each token beat is checked
// field by field. The stream stays well formed until a single error closes
// the run, after which all input must be ignored.
// ----------------------------------------------------------------------------
module mini_language_lexer_tb;
	import mll_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum {TAIL_NONE, TAIL_WORD, TAIL_NUM, TAIL_ANGLE, TAIL_OTHER} tail_t;

	logic     clk;
	logic     arst_n;
	logic     src_valid;
	logic     src_stall;
	lex_in_t  src_data;
	logic     tok_valid;
	logic     tok_stall;
	lex_tok_t tok_data;

	mini_language_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data (tok_data)
	);

	string      reserved_text [7] = '{"while", "do", "done", "if", "then", "fi", "print"};
	logic [4:0] reserved_code [7] = '{KIND_WHILE, KIND_DO, KIND_DONE, KIND_IF, KIND_THEN,
		KIND_FI, KIND_PRINT};
	string      op_text [12] = '{">", ">=", "==", "!=", "<=", "<", ":=", "+", "-", "*", "/",
		";"};

	// scanner state
	mode_t                  scan_mode  = MODE_IDLE;
	logic [7:0]             held_ch    = '0;
	logic [NUMBER_BITS-1:0] digit_acc  = '0;
	logic [7:0]             word_buf [MAX_WORD_LETTERS];
	int                     word_len   = 0;
	bit                     scan_halted = 1'b0;
	int                     step_emitted;

	lex_tok_t pending_toks [$];

	int    mismatches     = 0;
	int    tokens_checked = 0;
	int    beats_taken    = 0;
	int    items_sent     = 0;
	int    end_count      = 0;
	int    burst_left     = 0;
	int    cycle_count    = 0;
	string error_case     = "none";

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_op_char(logic [7:0] c);
		case (c)
			">", "<", "=", "!", ":", "+", "-", "*", "/", ";": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] blank_byte();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'd32 : 8'(9 + r);
	endfunction

	function automatic void emit_tok(logic [4:0] kind, logic [NUMBER_BITS-1:0] value,
		logic [7:0] letter, logic [1:0] err);
		lex_tok_t t;
		t.token_kind   = kind;
		t.number_value = value;
		t.name_letter  = letter;
		t.error_code   = err;
		t.last         = 1'b0;
		pending_toks.push_back(t);
		step_emitted++;
		if (kind == KIND_ERR)
			scan_halted = 1'b1;
	endfunction

	function automatic logic [4:0] reserved_kind();
		logic [4:0] k;
		bit         same;
		int         i;
		int         j;
		k = KIND_ERR;
		for (i = 0; i < 7; i++) begin
			if (reserved_text[i].len() == word_len) begin
				same = 1'b1;
				for (j = 0; j < word_len; j++)
					if (reserved_text[i][j] != word_buf[j])
						same = 1'b0;
				if (same)
					k = reserved_code[i];
			end
		end
		return k;
	endfunction

	function automatic void flush_pending();
		mode_t      m;
		logic [4:0] k;
		m = scan_mode;
		scan_mode = MODE_IDLE;
		case (m)
			MODE_NUM: emit_tok(KIND_NUM, digit_acc, 8'd0, ERR_NONE);
			MODE_WORD: begin
				if (word_len == 1) begin
					emit_tok(KIND_NAME, '0, word_buf[0], ERR_NONE);
				end else begin
					k = (word_len > MAX_WORD_LETTERS) ? KIND_ERR : reserved_kind();
					emit_tok(k, '0, 8'd0, (k == KIND_ERR) ? ERR_WORD : ERR_NONE);
				end
			end
			MODE_HELD: begin
				if (held_ch == ">")
					emit_tok(KIND_GT, '0, 8'd0, ERR_NONE);
				else if (held_ch == "<")
					emit_tok(KIND_LT, '0, 8'd0, ERR_NONE);
				else
					emit_tok(KIND_ERR, '0, 8'd0, ERR_SYMBOL);
			end
			default: ;
		endcase
	endfunction

	function automatic void open_token(logic [7:0] c);
		if (is_blank(c)) begin
			return;
		end else if (is_digit_ch(c)) begin
			scan_mode = MODE_NUM;
			digit_acc = NUMBER_BITS'(c - 8'd48);
		end else if (is_alpha(c)) begin
			scan_mode   = MODE_WORD;
			word_buf[0] = c;
			word_len    = 1;
		end else begin
			case (c)
				">", "<", "=", "!", ":": begin
					scan_mode = MODE_HELD;
					held_ch   = c;
				end
				"+": emit_tok(KIND_ADD, '0, 8'd0, ERR_NONE);
				"-": emit_tok(KIND_SUB, '0, 8'd0, ERR_NONE);
				"*": emit_tok(KIND_MUL, '0, 8'd0, ERR_NONE);
				"/": emit_tok(KIND_DIV, '0, 8'd0, ERR_NONE);
				";": emit_tok(KIND_SEMI, '0, 8'd0, ERR_NONE);
				default: emit_tok(KIND_ERR, '0, 8'd0, ERR_SYMBOL);
			endcase
		end
	endfunction

	// expected tokens for one accepted source beat
	function automatic void scan_beat(lex_in_t beat);
		logic [7:0]  c;
		logic [63:0] digit;
		logic [63:0] wide;
		logic [4:0]  k;
		step_emitted = 0;
		c = beat.char_code;
		if (scan_halted)
			return;
		if (beat.is_end) begin
			flush_pending();
			if (!scan_halted)
				emit_tok(KIND_END, '0, 8'd0, ERR_NONE);
		end else if (scan_mode == MODE_NUM && is_digit_ch(c)) begin
			digit = 64'(c) - 64'd48;
			wide  = 64'(digit_acc);
			if (wide > (64'(NUM_MAX) - digit) / 64'd10)
				digit_acc = NUM_MAX;
			else
				digit_acc = NUMBER_BITS'(wide * 64'd10 + digit);
		end else if (scan_mode == MODE_WORD && is_alpha(c)) begin
			if (word_len <= MAX_WORD_LETTERS) begin
				if (word_len < MAX_WORD_LETTERS)
					word_buf[word_len] = c;
				word_len++;
			end
		end else if (scan_mode == MODE_HELD && c == "=") begin
			case (held_ch)
				">": k = KIND_GE;
				"<": k = KIND_LE;
				"=": k = KIND_EQ;
				"!": k = KIND_NE;
				default: k = KIND_ASSIGN;
			endcase
			scan_mode = MODE_IDLE;
			emit_tok(k, '0, 8'd0, ERR_NONE);
		end else begin
			flush_pending();
			if (!scan_halted)
				open_token(c);
		end
		if (step_emitted > 0)
			pending_toks[pending_toks.size()-1].last = 1'b1;
	endfunction

	function automatic void check_token(lex_tok_t got);
		lex_tok_t want;
		if (pending_toks.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected token: kind %0d value %0d letter %02h err %0d last %0b",
					got.token_kind, got.number_value, got.name_letter, got.error_code,
					got.last);
			return;
		end
		want = pending_toks.pop_front();
		if (got.token_kind !== want.token_kind || got.number_value !== want.number_value ||
			got.name_letter !== want.name_letter || got.error_code !== want.error_code ||
			got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("token %0d exp: kind %0d value %0d letter %02h err %0d last %0b",
					tokens_checked, want.token_kind, want.number_value, want.name_letter,
					want.error_code, want.last);
				$display("token %0d got: kind %0d value %0d letter %02h err %0d last %0b",
					tokens_checked, got.token_kind, got.number_value, got.name_letter,
					got.error_code, got.last);
			end
		end
		tokens_checked++;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				scan_beat(src_data);
				beats_taken++;
			end
			if (tok_valid && !tok_stall)
				check_token(tok_data);
		end
	end

	// token side back-pressure: quiet, light, heavy and long runs in turn
	initial begin
		bit stall_now;
		int stall_run;
		int phase_cycle;
		stall_now   = 1'b0;
		stall_run   = 0;
		phase_cycle = 0;
		tok_stall   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			phase_cycle++;
			case ((phase_cycle / 160) % 4)
				0: stall_now = 1'b0;
				1: stall_now = ($urandom_range(0, 3) == 0);
				2: stall_now = ($urandom_range(0, 3) != 0);
				default: begin
					if (stall_run == 0) begin
						stall_now = !stall_now;
						stall_run = $urandom_range(1, 10);
					end
					stall_run--;
				end
			endcase
			tok_stall <= stall_now;
		end
	end

	task automatic send_beat(input logic [7:0] ch, input bit end_mark);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		src_valid <= 1'b1;
		src_data  <= '{char_code: ch, is_end: end_mark};
		do @(posedge clk); while (src_stall);
		items_sent++;
		if (end_mark)
			end_count++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	// every operator, lone less-than before a held symbol, end in idle
	task automatic test_operators();
		send_text(">>===!=<=<:=+-*/;");
		send_beat(8'hFF, 1'b1);
	endtask

	// zero, saturation, number cut by a letter, name cut by a lone greater-than
	task automatic test_numbers_and_names();
		send_text("0 4294967296Z>");
		send_beat(8'h80, 1'b1);
		send_text("7");
		send_beat(8'h00, 1'b1);
	endtask

	task automatic test_random_stream(input int budget);
		int         first_item;
		int         pick;
		int         len;
		int         i;
		string      piece;
		tail_t      tail;
		tail_t      next_tail;
		logic [7:0] lead;
		bit         must_split;
		first_item = items_sent;
		tail = TAIL_NONE;
		while (items_sent - first_item < budget) begin
			pick = $urandom_range(0, 99);
			piece = "";
			if (pick < 6) begin
				send_beat(8'($urandom_range(0, 255)), 1'b1);
				tail = TAIL_NONE;
			end else if (pick < 12) begin
				repeat ($urandom_range(1, 6)) send_beat(blank_byte(), 1'b0);
				tail = TAIL_NONE;
			end else begin
				if (pick < 36) begin
					if ($urandom_range(0, 9) == 0) begin
						piece = $sformatf("%0d", longint'(NUM_MAX) + $urandom_range(0, 2) - 1);
					end else begin
						len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16)
							: $urandom_range(1, 4);
						for (i = 0; i < len; i++)
							piece = $sformatf("%s%0d", piece, $urandom_range(0, 9));
					end
					next_tail = TAIL_NUM;
				end else if (pick < 52) begin
					piece = $sformatf("%c", (($urandom_range(0, 1) == 0) ? "a" : "A")
						+ $urandom_range(0, 25));
					next_tail = TAIL_WORD;
				end else if (pick < 70) begin
					piece = reserved_text[$urandom_range(0, 6)];
					next_tail = TAIL_WORD;
				end else begin
					piece = op_text[$urandom_range(0, 11)];
					next_tail = (piece == "<" || piece == ">") ? TAIL_ANGLE : TAIL_OTHER;
				end
				lead = piece[0];
				must_split = (tail == TAIL_WORD && is_alpha(lead)) ||
					(tail == TAIL_NUM && is_digit_ch(lead)) ||
					(tail == TAIL_ANGLE && lead == "=");
				if (must_split || $urandom_range(0, 2) == 0)
					send_beat(blank_byte(), 1'b0);
				send_text(piece);
				tail = next_tail;
			end
		end
	endtask

	// hold the source side until the token queue has drained
	task automatic test_drain_pause();
		src_valid <= 1'b0;
		do @(posedge clk); while (pending_toks.size() != 0);
	endtask

	// one error, chosen at random, then input that must be ignored
	task automatic test_error_halt();
		logic [7:0] c;
		int         len;
		int         i;
		string      word;
		word = "";
		case ($urandom_range(0, 3))
			0: begin
				error_case = "unknown symbol";
				do c = 8'($urandom_range(0, 255));
				while (is_blank(c) || is_digit_ch(c) || is_alpha(c) || is_op_char(c));
				send_text("x");
				send_beat(c, 1'b0);
			end
			1: begin
				error_case = "lone held symbol";
				case ($urandom_range(0, 2))
					0: send_text("=");
					1: send_text("!");
					default: send_text(":");
				endcase
				if ($urandom_range(0, 1) == 0) begin
					send_beat(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					do c = 8'($urandom_range(0, 255)); while (c == "=");
					send_beat(c, 1'b0);
				end
			end
			2: begin
				error_case = "unknown word";
				len = $urandom_range(2, MAX_WORD_LETTERS);
				for (i = 0; i < len; i++)
					word = $sformatf("%s%c", word, (($urandom_range(0, 1) == 0) ? "a" : "A")
						+ $urandom_range(0, 25));
				send_text(word);
				if ($urandom_range(0, 1) == 0)
					send_beat(8'($urandom_range(0, 255)), 1'b1);
				else
					send_text(";");
			end
			default: begin
				error_case = "overlong word";
				len = $urandom_range(MAX_WORD_LETTERS + 1, MAX_WORD_LETTERS + 5);
				for (i = 0; i < len; i++)
					word = $sformatf("%s%c", word, "a" + $urandom_range(0, 25));
				send_text(word);
				if ($urandom_range(0, 1) == 0)
					send_beat(8'($urandom_range(0, 255)), 1'b1);
				else
					send_beat(blank_byte(), 1'b0);
			end
		endcase
		repeat (30) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operators();
		test_numbers_and_names();
		test_random_stream(900);
		test_drain_pause();
		test_random_stream(950);
		test_drain_pause();
		test_error_halt();

		src_valid <= 1'b0;
		do @(posedge clk); while (pending_toks.size() != 0);
		repeat (16) @(posedge clk);
		if (pending_toks.size() != 0) begin
			mismatches += pending_toks.size();
			$display("%0d expected tokens never arrived", pending_toks.size());
		end

		$display("covered %0d source beats (%0d end markers) and %0d tokens in %0d cycles",
			beats_taken, end_count, tokens_checked, cycle_count);
		$display("closing error: %s, %0d mismatches", error_case, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
